// ===== rtl/core/gbs_pkg.sv =====
package gbs_pkg;

  localparam int MaxCandidates = 64;
  localparam int NumClasses = 80;
  localparam int OutLimit = 64;
  localparam int IdxW = $clog2(MaxCandidates);
  localparam int CntW = $clog2(MaxCandidates + 1);

  // configuration register indexes
  localparam logic [1:0] RegConf = 2'd0;
  localparam logic [1:0] RegIou = 2'd1;
  localparam logic [1:0] RegMaxDet = 2'd2;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0] box_width;
    logic [14:0] box_height;
    logic [15:0] score;
    logic [7:0] class_id;
    logic last_candidate;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [15:0] kept_score;
    logic [7:0] kept_class;
    logic last_result;
    logic none_found;
    logic overflow;
  } out_word_t;

  // one stored candidate as it moves along the chain
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [31:0] area;
    logic [15:0] score;
    logic [7:0] class_id;
  } box_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic insert;       // insert new box in score order
    logic pop;          // shift chain toward head, head leaves
    logic clear;        // drop everything
  } cell_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    else if (v < -18'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

endpackage

// ===== rtl/core/gbs_cell.sv =====
// one slot of the sorted chain: holds a box, its suppress mark and its valid bit
module gbs_cell (
  input  logic                clk,
  input  logic                rst,
  input  gbs_pkg::cell_ctl_t  ctl,
  input  gbs_pkg::box_t       new_box,
  input  gbs_pkg::box_t       prev_box,
  input  logic                prev_valid,
  input  logic                prev_goes_after,
  input  gbs_pkg::box_t       next_box,
  input  logic                next_valid,
  input  logic                next_supp,
  input  logic                kill,
  output gbs_pkg::box_t       box,
  output logic                valid,
  output logic                supp,
  output logic                goes_after
);

  // new box ranks after this one when its score is not higher (stable order)
  assign goes_after = valid && (new_box.score <= box.score);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
      supp <= 1'b0;
    end else if (ctl.insert) begin
      if (!goes_after) begin
        if (prev_goes_after) begin
          box <= new_box;
          valid <= 1'b1;
          supp <= 1'b0;
        end else begin
          box <= prev_box;
          valid <= prev_valid;
          supp <= 1'b0;
        end
      end
    end else if (ctl.pop) begin
      box <= next_box;
      valid <= next_valid;
      supp <= next_supp;
    end else if (kill) begin
      supp <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/gbs_iou.sv =====
// overlap check of head box against one cell: registered stages, at most one multiply each
module gbs_iou (
  input  logic                clk,
  input  gbs_pkg::box_t       a,
  input  gbs_pkg::box_t       b,
  input  logic [15:0]         overlap_thr,
  output logic                hit
);

  logic signed [15:0] x1, y1, x2, y2;
  logic [16:0] iw, ih;
  logic [16:0] iw_q, ih_q;
  logic [32:0] area_sum_q;
  logic [33:0] inter_q, uni;
  logic [33:0] uni_q;
  logic [33:0] inter_q2;
  logic [49:0] lhs;
  logic [49:0] rhs;

  always_comb begin
    x1 = (a.left > b.left) ? a.left : b.left;
    y1 = (a.top > b.top) ? a.top : b.top;
    x2 = (a.right < b.right) ? a.right : b.right;
    y2 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    iw = (x2 > x1) ? 17'(({x2[15], x2} - {x1[15], x1})) : 17'd0;
    ih = (y2 > y1) ? 17'(({y2[15], y2} - {y1[15], y1})) : 17'd0;
  end

  // stage 1: extents and area sum
  always_ff @(posedge clk) begin
    iw_q <= iw;
    ih_q <= ih;
    area_sum_q <= 33'(a.area) + 33'(b.area);
  end

  // stage 2: intersection
  always_ff @(posedge clk) begin
    inter_q <= 34'(iw_q * ih_q);
    uni_q <= 34'(area_sum_q);
  end

  assign uni = uni_q - inter_q;

  // stage 3: threshold product
  always_ff @(posedge clk) begin
    inter_q2 <= inter_q;
    rhs <= 50'(uni * overlap_thr);
  end

  assign lhs = {inter_q2[33:0], 16'd0};
  assign hit = lhs > rhs;

endmodule

// ===== rtl/core/greedy_box_suppression_unit.sv =====
// channel | direction | handshake              | word
// in      | in        | in_valid / in_ready    | gbs_pkg::in_word_t
// out     | out       | out_valid / out_ready  | gbs_pkg::out_word_t
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a candidate loads into a score-sorted chain of 64 cells. after the final
// candidate, a kept head goes through S_HEAD, which starts the compare against
// every cell (3-stage overlap pipe), S_WAIT while the pipe fills, and S_EMIT to
// emit and shift; a suppressed head goes from S_HEAD to S_EMIT. output stalls
// lengthen the pass. rst is synchronous and clears the chain.
// output stalls hold the head box in place; no input is taken during the pass.
module greedy_box_suppression_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbs_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output gbs_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int N = gbs_pkg::MaxCandidates;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_NONE = 3'd4;

  logic [2:0] state;
  logic [1:0] wait_cnt;
  logic [15:0] conf_threshold, overlap_thr;
  logic [6:0] max_detections;
  logic [gbs_pkg::CntW-1:0] count;
  logic [6:0] emitted;
  logic overflow_flag;

  gbs_pkg::cell_ctl_t ctl;
  gbs_pkg::box_t new_box;
  gbs_pkg::box_t boxes [N];
  logic valids [N];
  logic supps [N];
  logic after [N];
  logic hits [N];
  logic kill [N];
  logic same_cls [N];

  logic accept_in, qualifies, stores;
  logic [6:0] limit;
  logic signed [17:0] l18, r18, t18, b18;
  logic signed [15:0] l16, r16, t16, b16;
  logic [15:0] ext_w, ext_h;
  logic last_unsupp_head;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_LOAD);
  assign accept_in = in_valid && in_ready;
  assign qualifies = (in_word.score > conf_threshold) &&
                     (in_word.class_id < 8'(gbs_pkg::NumClasses));
  assign stores = accept_in && qualifies && (count < gbs_pkg::CntW'(N));
  assign limit = (max_detections > 7'(gbs_pkg::OutLimit)) ?
                 7'(gbs_pkg::OutLimit) : max_detections;

  // corner conversion and area
  always_comb begin
    l18 = 18'(in_word.pos_x) - 18'(in_word.box_width >> 1);
    r18 = l18 + 18'(in_word.box_width);
    t18 = 18'(in_word.pos_y) - 18'(in_word.box_height >> 1);
    b18 = t18 + 18'(in_word.box_height);
    l16 = gbs_pkg::sat16(l18);
    r16 = gbs_pkg::sat16(r18);
    t16 = gbs_pkg::sat16(t18);
    b16 = gbs_pkg::sat16(b18);
    ext_w = 16'(r16 - l16);
    ext_h = 16'(b16 - t16);
    new_box.left = l16;
    new_box.top = t16;
    new_box.right = r16;
    new_box.bottom = b16;
    new_box.area = {16'd0, ext_w} * {16'd0, ext_h};
    new_box.score = in_word.score;
    new_box.class_id = in_word.class_id;
  end

  // sequencer control; a suppressed head is popped without a word
  always_comb begin
    ctl.insert = stores;
    ctl.pop = (state == S_EMIT) && (supps[0] || out_ready);
    ctl.clear = (state == S_HEAD) && (!valids[0] || emitted >= limit);
  end

  // chain of cells with per-cell overlap units against the head
  for (genvar g = 0; g < N; g++) begin : g_cell
    gbs_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .new_box(new_box),
      .prev_box((g == 0) ? new_box : boxes[(g == 0) ? 0 : g - 1]),
      .prev_valid((g == 0) ? 1'b0 : valids[(g == 0) ? 0 : g - 1]),
      .prev_goes_after((g == 0) ? 1'b1 : after[(g == 0) ? 0 : g - 1]),
      .next_box(boxes[(g == N - 1) ? g : g + 1]),
      .next_valid((g == N - 1) ? 1'b0 : valids[(g == N - 1) ? g : g + 1]),
      .next_supp((g == N - 1) ? 1'b0 : supps[(g == N - 1) ? g : g + 1]),
      .kill(kill[g]),
      .box(boxes[g]), .valid(valids[g]), .supp(supps[g]), .goes_after(after[g])
    );
    gbs_iou u_iou (
      .clk(clk), .a(boxes[0]), .b(boxes[g]), .overlap_thr(overlap_thr),
      .hit(hits[g])
    );
    assign same_cls[g] = boxes[g].class_id == boxes[0].class_id;
    assign kill[g] = (g != 0) && (state == S_WAIT) && (wait_cnt == 2'd0) &&
                     valids[g] && same_cls[g] && hits[g];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      overflow_flag <= 1'b0;
      emitted <= '0;
      wait_cnt <= '0;
      conf_threshold <= 16'd16384;
      overlap_thr <= 16'd29491;
      max_detections <= 7'd64;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          gbs_pkg::RegConf: conf_threshold <= cfg_data;
          gbs_pkg::RegIou: overlap_thr <= cfg_data;
          gbs_pkg::RegMaxDet: max_detections <= cfg_data[6:0];
          default: ;
        endcase
      end
      unique case (state)
        S_LOAD: begin
          if (accept_in) begin
            if (stores) count <= count + 1'b1;
            else if (qualifies) overflow_flag <= 1'b1;
            if (in_word.last_candidate) state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (!valids[0] || emitted >= limit) begin
            state <= (emitted == 7'd0) ? S_NONE : S_LOAD;
            if (emitted != 7'd0) begin
              count <= '0;
              overflow_flag <= 1'b0;
              emitted <= '0;
            end
          end else if (supps[0]) begin
            state <= S_EMIT;
          end else begin
            wait_cnt <= 2'd2;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (wait_cnt == 2'd0) state <= S_EMIT;
          else wait_cnt <= wait_cnt - 1'b1;
        end
        S_EMIT: begin
          if (supps[0]) state <= S_HEAD;
          else if (out_ready) begin
            emitted <= emitted + 1'b1;
            state <= S_HEAD;
          end
        end
        S_NONE: begin
          if (out_ready) begin
            state <= S_LOAD;
            count <= '0;
            overflow_flag <= 1'b0;
            emitted <= '0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // final word when no unsuppressed box stays behind the head
  always_comb begin
    last_unsupp_head = 1'b1;
    for (int k = 1; k < N; k++) begin
      if (valids[k] && !supps[k]) last_unsupp_head = 1'b0;
    end
  end

  always_comb begin
    out_word = '0;
    out_valid = 1'b0;
    if (state == S_NONE) begin
      out_valid = 1'b1;
      out_word.last_result = 1'b1;
      out_word.none_found = 1'b1;
      out_word.overflow = overflow_flag;
    end else if (state == S_EMIT && !supps[0]) begin
      out_valid = 1'b1;
      out_word.left = boxes[0].left;
      out_word.top = boxes[0].top;
      out_word.right = boxes[0].right;
      out_word.bottom = boxes[0].bottom;
      out_word.kept_score = boxes[0].score;
      out_word.kept_class = boxes[0].class_id;
      out_word.overflow = overflow_flag;
      out_word.last_result = (emitted + 1'b1 >= limit) || last_unsupp_head;
    end
  end

endmodule

// ===== rtl/core/gbs_checker.sv =====
module gbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gbs_pkg::out_word_t out_word
);

  // no input taken while results are being shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during output");

  // an empty-result word is always the final one
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.none_found |-> out_word.last_result)
    else $error("none_found without last_result");

  // nothing is shown in the cycle after the final word
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_word.last_result |=> !out_valid)
    else $error("word shown right after final word");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("word changed while stalled");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one stored candidate as the predictor keeps it
  typedef struct {
    logic signed [15:0] l, t, r, b;
    logic [31:0] area;
    logic [15:0] score;
    logic [7:0] cls;
  } cand_t;

  // directed row: input word and, where obvious, its single result
  typedef struct {
    gbs_pkg::in_word_t w;
    bit has_exp;
    gbs_pkg::out_word_t exp;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  gbs_pkg::in_word_t in_word;
  gbs_pkg::out_word_t out_word;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  greedy_box_suppression_unit dut (.*);

  // predictor copy of registers and batch
  logic [15:0] conf_thr, iou_thr;
  logic [6:0] max_det;
  cand_t batch[$];
  bit dropped;
  gbs_pkg::out_word_t due_words[$];
  int errors, items_sent, sender_idle_pct, recv_idle_pct;
  logic [15:0] prev_score;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // random receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    gbs_pkg::out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        e = due_words.pop_front();
        if (out_word.left !== e.left) report("left", out_word.left, e.left);
        if (out_word.top !== e.top) report("top", out_word.top, e.top);
        if (out_word.right !== e.right) report("right", out_word.right, e.right);
        if (out_word.bottom !== e.bottom) report("bottom", out_word.bottom, e.bottom);
        if (out_word.kept_score !== e.kept_score)
          report("kept_score", out_word.kept_score, e.kept_score);
        if (out_word.kept_class !== e.kept_class)
          report("kept_class", out_word.kept_class, e.kept_class);
        if (out_word.last_result !== e.last_result)
          report("last_result", out_word.last_result, e.last_result);
        if (out_word.none_found !== e.none_found)
          report("none_found", out_word.none_found, e.none_found);
        if (out_word.overflow !== e.overflow)
          report("overflow", out_word.overflow, e.overflow);
      end
    end
  end

  // overlap test for same-class pairs, exact integer form
  function automatic bit too_much_overlap(cand_t a, cand_t c);
    int x1, y1, x2, y2;
    longint unsigned iw, ih, inter, uni;
    x1 = (a.l > c.l) ? a.l : c.l;
    y1 = (a.t > c.t) ? a.t : c.t;
    x2 = (a.r < c.r) ? a.r : c.r;
    y2 = (a.b < c.b) ? a.b : c.b;
    iw = (x2 > x1) ? longint'(x2 - x1) : 0;
    ih = (y2 > y1) ? longint'(y2 - y1) : 0;
    inter = iw * ih;
    uni = longint'(a.area) + longint'(c.area) - inter;
    return (inter << 16) > longint'(iou_thr) * uni;
  endfunction

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // load one candidate; on the final one run greedy suppression
  function automatic void nms_step(gbs_pkg::in_word_t w, ref gbs_pkg::out_word_t res[$]);
    int cx, cy, wd, ht, n, lim, pos, a, k;
    int order[$];
    bit supp[64];
    cand_t c;
    gbs_pkg::out_word_t o;
    res.delete();
    if (w.score > conf_thr && w.class_id < gbs_pkg::NumClasses) begin
      if (batch.size() < gbs_pkg::MaxCandidates) begin
        cx = w.pos_x; cy = w.pos_y; wd = w.box_width; ht = w.box_height;
        c.l = 16'(sat16(cx - (wd >>> 1)));
        c.r = 16'(sat16(cx - (wd >>> 1) + wd));
        c.t = 16'(sat16(cy - (ht >>> 1)));
        c.b = 16'(sat16(cy - (ht >>> 1) + ht));
        c.area = 32'(int'(c.r) - int'(c.l)) * 32'(int'(c.b) - int'(c.t));
        c.score = w.score;
        c.cls = w.class_id;
        batch.insert(batch.size(), c);
      end else begin
        dropped = 1'b1;
      end
    end
    if (!w.last_candidate) return;
    // stable sort by descending score
    n = batch.size();
    for (k = 0; k < n; k++) begin
      pos = order.size();
      while (pos > 0 && batch[order[pos - 1]].score < batch[k].score) pos--;
      order.insert(pos, k);
    end
    for (k = 0; k < 64; k++) supp[k] = 1'b0;
    lim = (max_det > gbs_pkg::OutLimit) ? gbs_pkg::OutLimit : max_det;
    for (int i = 0; i < n && res.size() < lim; i++) begin
      a = order[i];
      if (supp[a]) continue;
      for (int j = i + 1; j < n; j++)
        if (!supp[order[j]] && batch[order[j]].cls == batch[a].cls &&
            too_much_overlap(batch[a], batch[order[j]]))
          supp[order[j]] = 1'b1;
      o = '0;
      o.left = batch[a].l; o.top = batch[a].t;
      o.right = batch[a].r; o.bottom = batch[a].b;
      o.kept_score = batch[a].score;
      o.kept_class = batch[a].cls;
      o.overflow = dropped;
      res.insert(res.size(), o);
    end
    if (res.size() == 0) begin
      o = '0;
      o.none_found = 1'b1;
      o.overflow = dropped;
      res.insert(res.size(), o);
    end
    res[res.size() - 1].last_result = 1'b1;
    batch.delete();
    dropped = 1'b0;
  endfunction

  // drive one word; valid stays high across back-to-back words
  task automatic send_word(gbs_pkg::in_word_t w, bit has_exp, gbs_pkg::out_word_t exp);
    gbs_pkg::out_word_t res[$];
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    nms_step(w, res);
    if (has_exp) due_words.insert(due_words.size(), exp);
    else foreach (res[i]) due_words.insert(due_words.size(), res[i]);
    items_sent++;
    sender_idle_pct = (items_sent < 143) ? 26 : ((items_sent < 286) ? 69 : 0);
    recv_idle_pct = (items_sent < 143) ? 69 : ((items_sent < 286) ? 26 : 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gbs_pkg::RegConf: conf_thr = data;
      gbs_pkg::RegIou: iou_thr = data;
      gbs_pkg::RegMaxDet: max_det = data[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // registers are only touched once the block has drained
  task automatic set_regs(logic [15:0] cf, logic [15:0] io, logic [15:0] md);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(gbs_pkg::RegConf, cf);
    write_reg(gbs_pkg::RegIou, io);
    write_reg(gbs_pkg::RegMaxDet, md);
  endtask

  // mostly clustered boxes of few classes, some raw noise
  function automatic gbs_pkg::in_word_t rand_box();
    gbs_pkg::in_word_t w;
    logic [95:0] noise;
    if ($urandom_range(0, 99) < 20) begin
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(gbs_pkg::in_word_t)-1:0];
    end else begin
      w.pos_x = 16'($urandom_range(0, 200)) - 16'sd100;
      w.pos_y = 16'($urandom_range(0, 200)) - 16'sd100;
      w.box_width = 15'($urandom_range(0, 160));
      w.box_height = 15'($urandom_range(0, 160));
      w.score = 16'($urandom_range(0, 65535));
      w.class_id = 8'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 99) < 20) w.score = prev_score;
    prev_score = w.score;
    w.last_candidate = 1'b0;
    return w;
  endfunction

  function automatic gbs_pkg::in_word_t mk(int cx, int cy, int wd, int ht, int sc, int cl,
                                           bit lst);
    gbs_pkg::in_word_t w;
    w.pos_x = 16'(cx); w.pos_y = 16'(cy);
    w.box_width = 15'(wd); w.box_height = 15'(ht);
    w.score = 16'(sc); w.class_id = 8'(cl); w.last_candidate = lst;
    return w;
  endfunction

  function automatic gbs_pkg::out_word_t kept(int l, int t, int r, int b, int sc, int cl);
    gbs_pkg::out_word_t o;
    o = '0;
    o.left = 16'(l); o.top = 16'(t); o.right = 16'(r); o.bottom = 16'(b);
    o.kept_score = 16'(sc); o.kept_class = 8'(cl); o.last_result = 1'b1;
    return o;
  endfunction

  // stimulus
  initial begin
    row_t rows[$];
    gbs_pkg::out_word_t empty_word, none_word;
    gbs_pkg::in_word_t w;
    int nb, settings;
    empty_word = '0;
    none_word = '0;
    none_word.none_found = 1'b1;
    none_word.last_result = 1'b1;
    errors = 0; items_sent = 0; dropped = 1'b0; prev_score = '0;
    sender_idle_pct = 26; recv_idle_pct = 69;
    conf_thr = 16'd16384; iou_thr = 16'd29491; max_det = 7'd64;
    rst <= 1'b1;
    in_valid <= 1'b0; in_word <= '0;
    cfg_valid <= 1'b0; cfg_index <= gbs_pkg::RegConf; cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset settings
    rows.insert(rows.size(), row_t'{mk(0, 0, 32, 32, 0, 0, 1), 1'b1, none_word});
    rows.insert(rows.size(), row_t'{mk(0, 0, 32, 32, 16384, 0, 1), 1'b1, none_word});
    rows.insert(rows.size(), row_t'{mk(0, 0, 32, 32, 65535, 0, 1), 1'b1,
                                    kept(-16, -16, 16, 16, 65535, 0)});
    rows.insert(rows.size(), row_t'{mk(32767, -32768, 32767, 32767, 16385, 79, 1), 1'b1,
                                    kept(16384, -32768, 32767, -16384, 16385, 79)});
    rows.insert(rows.size(), row_t'{mk(-32768, 32767, 0, 0, 65535, 80, 1), 1'b1,
                                    none_word});
    rows.insert(rows.size(), row_t'{mk(5, 5, 10, 10, 60000, 255, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(-32768, 32767, 1, 1, 20000, 7, 1), 1'b0,
                                    empty_word});
    // equal scores, same class, heavy overlap: earlier one wins
    rows.insert(rows.size(), row_t'{mk(0, 0, 100, 100, 40000, 3, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(2, 2, 100, 100, 40000, 3, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(0, 0, 100, 100, 50000, 4, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(0, 0, 100, 100, 45000, 5, 1), 1'b0, empty_word});
    // zero-area boxes give a zero union
    rows.insert(rows.size(), row_t'{mk(10, 10, 0, 0, 30000, 1, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(10, 10, 0, 0, 30000, 1, 1), 1'b0, empty_word});
    // lower score overlapping box of the same class
    rows.insert(rows.size(), row_t'{mk(0, 0, 64, 64, 30000, 2, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(4, 0, 64, 64, 50000, 2, 0), 1'b0, empty_word});
    rows.insert(rows.size(), row_t'{mk(200, 200, 64, 64, 20000, 2, 1), 1'b0, empty_word});
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp);

    // random batches across several register settings
    settings = 0;
    while (items_sent < 430) begin
      if (items_sent >= settings * 70) begin
        case (settings % 6)
          0: set_regs(16'd0, 16'd0, 16'd1);
          1: set_regs(16'hffff, 16'hffff, 16'd127);
          2: set_regs(16'd0, 16'hffff, 16'd0);
          3: set_regs(16'd100, 16'd32768, 16'd64);
          4: set_regs(16'd16384, 16'd29491, 16'd3);
          default: set_regs(16'($urandom_range(0, 40000)), 16'($urandom),
                            16'($urandom_range(1, 64)));
        endcase
        settings++;
      end
      nb = ($urandom_range(0, 99) < 10) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      for (int k = 0; k < nb; k++) begin
        w = rand_box();
        w.last_candidate = (k == nb - 1);
        send_word(w, 1'b0, empty_word);
      end
    end
    in_valid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // hard stop
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gbs_pkg.sv
rtl/core/gbs_cell.sv
rtl/core/gbs_iou.sv
rtl/core/greedy_box_suppression_unit.sv
rtl/core/gbs_checker.sv
tb/sv/testbench.sv
